// ===== rtl/tccs_pkg.sv =====
// ----------------------------------------------------------------------------
// tccs_pkg
// Shared types and constants for the text console cursor/scroll engine:
// channel payloads, request and register codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tccs_pkg;

   // request codes
   localparam logic [1:0] REQ_PUT    = 2'd0;
   localparam logic [1:0] REQ_DIRECT = 2'd1;
   localparam logic [1:0] REQ_READ   = 2'd2;

   // configuration register indexes
   localparam logic CSR_DEFAULT_FG = 1'b0;
   localparam logic CSR_DEFAULT_BG = 1'b1;

   // character codes and reset attribute
   localparam logic [7:0] NEWLINE_CODE = 8'd10;
   localparam logic [7:0] SPACE_CODE   = 8'h20;
   localparam logic [3:0] RESET_FG     = 4'd7;
   localparam logic [3:0] RESET_BG     = 4'd0;

   localparam int OFFSET_W = 11;
   localparam int POS_W    = 11;

   typedef struct packed {
      logic [1:0]          req_type;
      logic [7:0]          char_code;
      logic [OFFSET_W-1:0] cell_offset;
      logic [3:0]          fg_colour;
      logic [3:0]          bg_colour;
   } req_payload_type;

   typedef struct packed {
      logic [15:0]      cell_data;
      logic [POS_W-1:0] cursor_pos;
      logic             cursor_updated;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_CHECK,
      ST_COPY,
      ST_BLANK,
      ST_PUT,
      ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic latch;      // capture accepted item
      logic newline;    // column to 0, row up (saturating)
      logic wrap;       // wrap at right edge if needed
      logic direct_wr;  // direct cell write
      logic rd_issue;   // read cell at offset
      logic clear_wr;   // reset blank at sweep count
      logic copy_step;  // one step of the row copy
      logic blank_wr;   // default blank at sweep count
      logic row_bottom; // row to last row
      logic put_wr;     // write put cell, advance column
      logic cnt_clr;
      logic cnt_inc;
      logic rsp_load;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] req_type;
      logic       is_newline;
      logic       row_past;
      logic       cnt_copy_end;
      logic       cnt_end;
      logic       rsp_free;
   } ctrl_status_type;

endpackage

// ===== rtl/text_console_cursor_scroll.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_scroll
// Text console engine: ROWS x COLUMNS cell store with cursor, put-character
// with newline, wrap and scroll, direct cell write and cell read.
// ----------------------------------------------------------------------------
//  channel   ports                            direction
//  request   req_valid, req_stall, req_data   in  (req_stall driven here)
//  result    rsp_valid, rsp_stall, rsp_data   out (rsp_stall driven by sink)
//  config    csr_wr_en, csr_index, csr_wr_data in, write only
//
//  One item at a time: direct write, read, newline and unused codes go
//  from accept through decode to the result; a printable put also checks
//  the row and writes the cell. A put that scrolls first has the cell store
//  copy one cell per cycle, then blank the last row one cell per cycle.
//  After reset a clearing pass over every cell holds req_stall high.
//  An item is taken while a result is stalled; it then waits in its final step.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  tccs_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output tccs_pkg::rsp_payload_type rsp_data,
   input  logic                      csr_wr_en,
   input  logic                      csr_index,
   input  logic [3:0]                csr_wr_data
);

   tccs_pkg::ctrl_cmd_type    cmd;
   tccs_pkg::ctrl_status_type status;

   // sequencer
   tccs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // store, cursor and result
   tccs_dp #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

// ===== rtl/tccs_ctrl.sv =====
// ----------------------------------------------------------------------------
// tccs_ctrl
// Controller state machine: reset clear pass, request decode, scroll
// sequencing (row copy then blanking) and result hand-off.
// ----------------------------------------------------------------------------
module tccs_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  tccs_pkg::ctrl_status_type status,
   output tccs_pkg::ctrl_cmd_type    cmd
);

   tccs_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tccs_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         tccs_pkg::ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.cnt_end) begin
               cmd.cnt_clr = 1'b1;
               state_in    = tccs_pkg::ST_IDLE;
            end else begin
               cmd.cnt_inc = 1'b1;
            end
         end
         tccs_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = tccs_pkg::ST_DECODE;
            end
         end
         tccs_pkg::ST_DECODE: begin
            state_in = tccs_pkg::ST_DONE;
            case (status.req_type)
               tccs_pkg::REQ_PUT: begin
                  if (status.is_newline) begin
                     cmd.newline = 1'b1;
                  end else begin
                     cmd.wrap = 1'b1;
                     state_in = tccs_pkg::ST_CHECK;
                  end
               end
               tccs_pkg::REQ_DIRECT: cmd.direct_wr = 1'b1;
               tccs_pkg::REQ_READ:   cmd.rd_issue  = 1'b1;
               default:              ;
            endcase
         end
         tccs_pkg::ST_CHECK: begin
            if (status.row_past) begin
               cmd.cnt_clr = 1'b1;
               state_in    = tccs_pkg::ST_COPY;
            end else begin
               state_in = tccs_pkg::ST_PUT;
            end
         end
         tccs_pkg::ST_COPY: begin
            cmd.copy_step = 1'b1;
            if (status.cnt_copy_end) begin
               state_in = tccs_pkg::ST_BLANK;
            end else begin
               cmd.cnt_inc = 1'b1;
            end
         end
         tccs_pkg::ST_BLANK: begin
            cmd.blank_wr = 1'b1;
            if (status.cnt_end) begin
               cmd.row_bottom = 1'b1;
               cmd.cnt_clr    = 1'b1;
               state_in       = tccs_pkg::ST_PUT;
            end else begin
               cmd.cnt_inc = 1'b1;
            end
         end
         tccs_pkg::ST_PUT: begin
            cmd.put_wr = 1'b1;
            state_in   = tccs_pkg::ST_DONE;
         end
         tccs_pkg::ST_DONE: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = tccs_pkg::ST_IDLE;
            end
         end
         default: state_in = tccs_pkg::ST_IDLE;
      endcase
   end

endmodule

// ===== rtl/tccs_dp.sv =====
// ----------------------------------------------------------------------------
// tccs_dp
// Datapath: cell store, cursor, default colour registers, sweep counter,
// item latch and result register.
// ----------------------------------------------------------------------------
module tccs_dp #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                      clock,
   input  logic                      reset,
   input  tccs_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output tccs_pkg::rsp_payload_type rsp_data,
   input  logic                      csr_wr_en,
   input  logic                      csr_index,
   input  logic [3:0]                csr_wr_data,
   input  tccs_pkg::ctrl_cmd_type    cmd,
   output tccs_pkg::ctrl_status_type status
);

   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int CLW   = $clog2(CELLS + 1);
   localparam int NW    = (CLW > tccs_pkg::OFFSET_W) ? CLW : tccs_pkg::OFFSET_W;
   localparam int CW    = $clog2(COLUMNS + 1);
   localparam int RW    = $clog2(ROWS + 1);

   localparam logic [AW-1:0] CNT_LAST     = AW'(CELLS - 1);
   localparam logic [AW-1:0] CNT_COPY_END = AW'(CELLS - COLUMNS);
   localparam logic [NW-1:0] CELLS_N      = NW'(CELLS);
   localparam logic [CW-1:0] COLS_C       = CW'(COLUMNS);
   localparam logic [RW-1:0] ROWS_R       = RW'(ROWS);

   logic [15:0] mem [CELLS];
   logic [15:0] rd_data_ff;

   tccs_pkg::req_payload_type item_ff;
   tccs_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]             col_ff, col_in;
   logic [RW-1:0]             row_ff, row_in;
   logic [3:0]                def_fg_ff, def_bg_ff;
   logic [AW-1:0]             cnt_ff, cnt_in;

   logic [RW-1:0] row_inc;
   logic [NW-1:0] off_ext;
   logic [AW-1:0] off_addr;
   logic          off_ok;
   logic [NW-1:0] cur_idx;
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_wa, mem_ra;
   logic [15:0]   mem_wd;
   logic          put_printable;

   // offset range check and cursor index
   assign off_ext  = NW'(item_ff.cell_offset);
   assign off_addr = off_ext[AW-1:0];
   assign off_ok   = off_ext < CELLS_N;
   assign cur_idx  = NW'(row_ff) * NW'(COLUMNS) + NW'(col_ff);
   assign row_inc  = (row_ff < ROWS_R) ? RW'(row_ff + RW'(1)) : row_ff;

   // store write/read port selection
   always_comb begin
      mem_we = 1'b0;
      mem_re = 1'b0;
      mem_wa = cnt_ff;
      mem_ra = off_addr;
      mem_wd = {tccs_pkg::RESET_BG, tccs_pkg::RESET_FG, tccs_pkg::SPACE_CODE};
      if (cmd.clear_wr) begin
         mem_we = 1'b1;
      end
      if (cmd.copy_step) begin
         mem_we = (cnt_ff != '0);
         mem_wa = AW'(cnt_ff - AW'(1));
         mem_wd = rd_data_ff;
         mem_re = (cnt_ff < CNT_COPY_END);
         mem_ra = AW'(cnt_ff + AW'(COLUMNS));
      end
      if (cmd.blank_wr) begin
         mem_we = 1'b1;
         mem_wd = {def_bg_ff, def_fg_ff, tccs_pkg::SPACE_CODE};
      end
      if (cmd.direct_wr) begin
         mem_we = off_ok;
         mem_wa = off_addr;
         mem_wd = {item_ff.bg_colour, item_ff.fg_colour, item_ff.char_code};
      end
      if (cmd.rd_issue) begin
         mem_re = off_ok;
      end
      if (cmd.put_wr) begin
         mem_we = 1'b1;
         mem_wa = cur_idx[AW-1:0];
         mem_wd = {def_bg_ff, def_fg_ff, item_ff.char_code};
      end
   end

   // cell store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_ra];
      end
   end

   // cursor and sweep counter next values
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      cnt_in = cnt_ff;
      if (cmd.newline) begin
         col_in = '0;
         row_in = row_inc;
      end
      if (cmd.wrap && (col_ff >= COLS_C)) begin
         col_in = '0;
         row_in = row_inc;
      end
      if (cmd.row_bottom) begin
         row_in = RW'(ROWS - 1);
      end
      if (cmd.put_wr) begin
         col_in = CW'(col_ff + CW'(1));
      end
      if (cmd.cnt_clr) begin
         cnt_in = '0;
      end else if (cmd.cnt_inc) begin
         cnt_in = AW'(cnt_ff + AW'(1));
      end
   end

   // result assembly
   assign put_printable = (item_ff.req_type == tccs_pkg::REQ_PUT) &&
                          (item_ff.char_code != tccs_pkg::NEWLINE_CODE);

   always_comb begin
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.rsp_load) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.cell_data       = ((item_ff.req_type == tccs_pkg::REQ_READ) && off_ok)
                                       ? rd_data_ff : 16'd0;
         rsp_data_in.cursor_pos      = put_printable ? cur_idx[tccs_pkg::POS_W-1:0] : '0;
         rsp_data_in.cursor_updated  = put_printable;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         def_fg_ff    <= tccs_pkg::RESET_FG;
         def_bg_ff    <= tccs_pkg::RESET_BG;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en && (csr_index == tccs_pkg::CSR_DEFAULT_FG)) begin
            def_fg_ff <= csr_wr_data;
         end
         if (csr_wr_en && (csr_index == tccs_pkg::CSR_DEFAULT_BG)) begin
            def_bg_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         item_ff <= req_data;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // status to controller
   assign status.req_type     = item_ff.req_type;
   assign status.is_newline   = (item_ff.char_code == tccs_pkg::NEWLINE_CODE);
   assign status.row_past     = (row_ff >= ROWS_R);
   assign status.cnt_copy_end = (cnt_ff == CNT_COPY_END);
   assign status.cnt_end      = (cnt_ff == CNT_LAST);
   assign status.rsp_free     = !rsp_valid_ff || !rsp_stall;

endmodule

// ===== tb/tccs_checker.sv =====
// ----------------------------------------------------------------------------
// tccs_checker
// Watches the request, result and register channels of the text console
// engine. It keeps its own copy of the cell store, the cursor and the default
// colours, works out the result of every accepted item and checks each
// accepted result, field by field, against the oldest outstanding one.
// ----------------------------------------------------------------------------
module tccs_checker #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  tccs_pkg::req_payload_type req_data,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  tccs_pkg::rsp_payload_type rsp_data,
   input  logic                      csr_wr_en,
   input  logic                      csr_index,
   input  logic [3:0]                csr_wr_data,
   input  logic                      drain_done,
   output int unsigned               error_count,
   output int unsigned               result_count,
   output int unsigned               scroll_count,
   output int unsigned               read_count
);

   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int IDX_W      = $clog2(CELL_COUNT);
   localparam int COL_W      = $clog2(COLUMNS + 1);
   localparam int ROW_W      = $clog2(ROWS + 1);

   // shadow console state
   logic [15:0]      screen [CELL_COUNT];
   logic [COL_W-1:0] cursor_col;
   logic [ROW_W-1:0] cursor_row;
   logic [3:0]       fg_default;
   logic [3:0]       bg_default;
   int unsigned      scrolls;
   int unsigned      reads;
   bit               leftover_checked;

   // results owed by the block, oldest first
   tccs_pkg::rsp_payload_type owed_rsp_q[$];

   function automatic logic [15:0] cell_word(logic [7:0] ch, logic [3:0] fg, logic [3:0] bg);
      return {bg, fg, ch};
   endfunction

   // shift everything up one row and blank the bottom row
   function automatic void scroll_screen();
      for (int i = COLUMNS; i < CELL_COUNT; i++)
         screen[IDX_W'(i - COLUMNS)] = screen[IDX_W'(i)];
      for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
         screen[IDX_W'(i)] = cell_word(tccs_pkg::SPACE_CODE, fg_default, bg_default);
      cursor_row = ROW_W'(ROWS - 1);
      scrolls++;
   endfunction

   function automatic void next_row();
      if (cursor_row < ROWS) cursor_row = cursor_row + 1'b1;
   endfunction

   // apply one item to the shadow state and return the result it owes
   function automatic tccs_pkg::rsp_payload_type console_result(
      tccs_pkg::req_payload_type r);
      tccs_pkg::rsp_payload_type res;
      int unsigned               idx;
      res = '0;
      case (r.req_type)
         tccs_pkg::REQ_PUT: begin
            if (r.char_code == tccs_pkg::NEWLINE_CODE) begin
               cursor_col = '0;
               next_row();
            end else begin
               if (cursor_col >= COLUMNS) begin
                  cursor_col = '0;
                  next_row();
               end
               if (cursor_row >= ROWS) scroll_screen();
               idx = cursor_row * COLUMNS + cursor_col;
               if (idx < CELL_COUNT)
                  screen[IDX_W'(idx)] = cell_word(r.char_code, fg_default, bg_default);
               cursor_col = cursor_col + 1'b1;
               idx = cursor_row * COLUMNS + cursor_col;
               res.cursor_pos     = idx[tccs_pkg::POS_W-1:0];
               res.cursor_updated = 1'b1;
            end
         end
         tccs_pkg::REQ_DIRECT: begin
            if (r.cell_offset < CELL_COUNT)
               screen[IDX_W'(r.cell_offset)] =
                  cell_word(r.char_code, r.fg_colour, r.bg_colour);
         end
         tccs_pkg::REQ_READ: begin
            reads++;
            if (r.cell_offset < CELL_COUNT) res.cell_data = screen[IDX_W'(r.cell_offset)];
         end
         default: ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      tccs_pkg::rsp_payload_type want;
      int unsigned               bad;
      bad = 0;
      if (reset) begin
         for (int i = 0; i < CELL_COUNT; i++)
            screen[IDX_W'(i)] = cell_word(tccs_pkg::SPACE_CODE, tccs_pkg::RESET_FG,
                                          tccs_pkg::RESET_BG);
         cursor_col = '0;
         cursor_row = '0;
         fg_default = tccs_pkg::RESET_FG;
         bg_default = tccs_pkg::RESET_BG;
         scrolls    = 0;
         reads      = 0;
         leftover_checked = 1'b0;
         owed_rsp_q.delete();
         error_count  <= 0;
         result_count <= 0;
         scroll_count <= 0;
         read_count   <= 0;
      end else begin
         // register writes land before any item taken on the same edge
         if (csr_wr_en) begin
            case (csr_index)
               tccs_pkg::CSR_DEFAULT_FG: fg_default = csr_wr_data;
               tccs_pkg::CSR_DEFAULT_BG: bg_default = csr_wr_data;
               default: ;
            endcase
         end

         if (req_valid && !req_stall) owed_rsp_q.push_back(console_result(req_data));

         if (rsp_valid && !rsp_stall) begin
            result_count <= result_count + 1;
            if (owed_rsp_q.size() == 0) begin
               bad++;
               $display("%0t: unexpected result, expected none, got %h", $time, rsp_data);
            end else begin
               want = owed_rsp_q.pop_front();
               if (rsp_data !== want) begin
                  bad++;
                  if (rsp_data.cell_data !== want.cell_data)
                     $display("%0t: cell_data expected %h got %h",
                              $time, want.cell_data, rsp_data.cell_data);
                  if (rsp_data.cursor_pos !== want.cursor_pos)
                     $display("%0t: cursor_pos expected %0d got %0d",
                              $time, want.cursor_pos, rsp_data.cursor_pos);
                  if (rsp_data.cursor_updated !== want.cursor_updated)
                     $display("%0t: cursor_updated expected %b got %b",
                              $time, want.cursor_updated, rsp_data.cursor_updated);
               end
            end
         end

         // anything still owed once the run has drained is missing
         if (drain_done && !leftover_checked) begin
            leftover_checked = 1'b1;
            if (owed_rsp_q.size() != 0) begin
               bad++;
               $display("%0t: results missing, expected %0d more, got 0",
                        $time, owed_rsp_q.size());
            end
         end
         error_count  <= error_count + bad;
         scroll_count <= scrolls;
         read_count   <= reads;
      end
   end

endmodule

// ===== tb/tb_text_console_cursor_scroll.sv =====
// ----------------------------------------------------------------------------
// tb_text_console_cursor_scroll
// Drives the text console engine with a short directed set of items, then
// randomized bursts of text, newlines, direct writes, reads and unused codes
// under several default-colour settings, with random idling on both channels.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_text_console_cursor_scroll;

   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int PHASES     = 6;
   localparam int PHASE_ITEMS = 300;
   localparam int REQ_W      = $bits(tccs_pkg::req_payload_type);

   // request code with no operation behind it
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   logic                      clock;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_stall;
   tccs_pkg::req_payload_type req_data    = '0;
   logic                      rsp_valid;
   logic                      rsp_stall   = 1'b0;
   tccs_pkg::rsp_payload_type rsp_data;
   logic                      csr_wr_en   = 1'b0;
   logic                      csr_index   = tccs_pkg::CSR_DEFAULT_FG;
   logic [3:0]                csr_wr_data = '0;
   logic                      drain_done  = 1'b0;
   logic                      idle_en     = 1'b1;

   int unsigned     error_count;
   int unsigned     result_count;
   int unsigned     scroll_count;
   int unsigned     read_count;
   int unsigned     sent_count = 0;
   int unsigned     stall_left = 0;

   text_console_cursor_scroll #(.COLUMNS(COLUMNS), .ROWS(ROWS)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   tccs_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wr_data  (csr_wr_data),
      .drain_done   (drain_done),
      .error_count  (error_count),
      .result_count (result_count),
      .scroll_count (scroll_count),
      .read_count   (read_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit: far beyond a run where every put scrolls and every step stalls
   initial begin
      #100000000;
      $display("Some tests failed");
      $finish;
   end

   // result side back-pressure in bursts of random length
   always @(posedge clock) begin
      if (reset || !idle_en) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 3);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic tccs_pkg::req_payload_type make_req(logic [1:0] kind, logic [7:0] ch,
                                                          logic [10:0] offset,
                                                          logic [3:0] fg, logic [3:0] bg);
      tccs_pkg::req_payload_type r;
      r.req_type    = kind;
      r.char_code   = ch;
      r.cell_offset = offset;
      r.fg_colour   = fg;
      r.bg_colour   = bg;
      return r;
   endfunction

   function automatic logic [7:0] printable_char();
      logic [7:0] ch;
      do ch = 8'($urandom_range(0, 255)); while (ch == tccs_pkg::NEWLINE_CODE);
      return ch;
   endfunction

   function automatic logic [3:0] any_colour();
      return 4'($urandom_range(0, 15));
   endfunction

   // mostly the bottom rows, where puts and scrolls land, plus out-of-range offsets
   function automatic logic [10:0] pick_offset();
      int unsigned roll;
      roll = $urandom_range(0, 19);
      if (roll < 2) return 11'($urandom_range(CELL_COUNT, 2047));
      if (roll < 11) return 11'($urandom_range(CELL_COUNT - 4 * COLUMNS, CELL_COUNT - 1));
      return 11'($urandom_range(0, CELL_COUNT - 1));
   endfunction

   // present one item and hold it until taken
   task automatic send_req(input tccs_pkg::req_payload_type r);
      if (idle_en && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      sent_count++;
   endtask

   task automatic wait_results();
      req_valid <= 1'b0;
      while (result_count != sent_count) @(posedge clock);
   endtask

   task automatic write_defaults(input logic [3:0] fg, input logic [3:0] bg);
      csr_wr_en   <= 1'b1;
      csr_index   <= tccs_pkg::CSR_DEFAULT_FG;
      csr_wr_data <= fg;
      @(posedge clock);
      csr_index   <= tccs_pkg::CSR_DEFAULT_BG;
      csr_wr_data <= bg;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic put_char(input logic [7:0] ch);
      send_req(make_req(tccs_pkg::REQ_PUT, ch, 11'($urandom_range(0, 2047)),
                        any_colour(), any_colour()));
   endtask

   // one randomized burst of related items
   task automatic random_burst(inout int unsigned count);
      int unsigned kind;
      int unsigned len;
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
         // text run, long enough at times to wrap
         len = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 20);
         repeat (len) put_char(printable_char());
      end else if (kind < 55) begin
         // newlines; long runs saturate the row at the bottom
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 30) : $urandom_range(1, 2);
         repeat (len) put_char(tccs_pkg::NEWLINE_CODE);
      end else if (kind < 70) begin
         len = $urandom_range(1, 4);
         repeat (len)
            send_req(make_req(tccs_pkg::REQ_DIRECT, 8'($urandom_range(0, 255)),
                              pick_offset(), any_colour(), any_colour()));
      end else if (kind < 92) begin
         len = $urandom_range(1, 6);
         repeat (len)
            send_req(make_req(tccs_pkg::REQ_READ, 8'($urandom_range(0, 255)),
                              pick_offset(), any_colour(), any_colour()));
      end else if (kind < 96) begin
         len = 1;
         send_req(make_req(REQ_UNUSED, 8'($urandom_range(0, 255)),
                           11'($urandom_range(0, 2047)), any_colour(), any_colour()));
      end else begin
         // unshaped items
         len = $urandom_range(1, 3);
         repeat (len) send_req(tccs_pkg::req_payload_type'(REQ_W'($urandom)));
      end
      count += len;
   endtask

   initial begin
      logic [3:0]  fg_set [PHASES];
      logic [3:0]  bg_set [PHASES];
      int unsigned phase_count;

      fg_set = '{4'd15, 4'd0, 4'd15, 4'd0, 4'd0, tccs_pkg::RESET_FG};
      bg_set = '{4'd15, 4'd0, 4'd0,  4'd15, 4'd0, tccs_pkg::RESET_BG};
      fg_set[4] = any_colour();
      bg_set[4] = any_colour();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: reset contents, store extremes, ignored offsets, unused code, puts
      send_req(make_req(tccs_pkg::REQ_READ, 8'h00, 11'd0, 4'h0, 4'h0));
      send_req(make_req(tccs_pkg::REQ_READ, 8'hFF, 11'(CELL_COUNT - 1), 4'hF, 4'hF));
      send_req(make_req(tccs_pkg::REQ_READ, 8'h00, 11'(CELL_COUNT), 4'h0, 4'h0));
      send_req(make_req(tccs_pkg::REQ_READ, 8'h00, 11'h7FF, 4'h0, 4'h0));
      send_req(make_req(tccs_pkg::REQ_DIRECT, 8'hFF, 11'd0, 4'hF, 4'hF));
      send_req(make_req(tccs_pkg::REQ_READ, 8'h00, 11'd0, 4'h0, 4'h0));
      send_req(make_req(tccs_pkg::REQ_DIRECT, 8'h00, 11'(CELL_COUNT - 1), 4'h0, 4'h0));
      send_req(make_req(tccs_pkg::REQ_READ, 8'h00, 11'(CELL_COUNT - 1), 4'h0, 4'h0));
      send_req(make_req(tccs_pkg::REQ_DIRECT, 8'hAA, 11'(CELL_COUNT), 4'h5, 4'hA));
      send_req(make_req(tccs_pkg::REQ_DIRECT, 8'h55, 11'h7FF, 4'hA, 4'h5));
      send_req(make_req(tccs_pkg::REQ_READ, 8'h00, 11'(CELL_COUNT - 1), 4'h0, 4'h0));
      send_req(make_req(REQ_UNUSED, 8'hFF, 11'h7FF, 4'hF, 4'hF));
      send_req(make_req(REQ_UNUSED, 8'h00, 11'd0, 4'h0, 4'h0));
      put_char(8'h48);
      put_char(8'h00);
      put_char(8'hFF);
      put_char(tccs_pkg::NEWLINE_CODE);
      put_char(8'h69);
      send_req(make_req(tccs_pkg::REQ_READ, 8'h00, 11'(COLUMNS), 4'h0, 4'h0));
      send_req(make_req(tccs_pkg::REQ_READ, 8'h00, 11'd0, 4'h0, 4'h0));
      send_req(make_req(tccs_pkg::REQ_READ, 8'h00, 11'd2, 4'h0, 4'h0));
      put_char(tccs_pkg::NEWLINE_CODE);
      wait_results();

      // random phases, each under its own default colours
      for (int p = 0; p < PHASES; p++) begin
         write_defaults(fg_set[p], bg_set[p]);
         phase_count = 0;
         while (phase_count < PHASE_ITEMS) begin
            // occasional stretches with no idling; the final phase has none
            idle_en <= (p != PHASES - 1) && ($urandom_range(0, 6) != 0);
            random_burst(phase_count);
         end
         wait_results();
      end

      repeat (12) @(posedge clock);
      drain_done <= 1'b1;
      repeat (2) @(posedge clock);

      $display("Sent %0d items and checked %0d results: %0d scrolls, %0d cell reads.",
               sent_count, result_count, scroll_count, read_count);
      $display("Default colours went through %0d settings, both extremes included.", PHASES);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
